/* rtl/ttw_pkg.sv */
// Shared constants, command codes and controller/datapath interface types
// for the text terminal writer. No dependencies.
package ttw_pkg;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int COPY_COUNT = COLUMNS * (ROWS - 1);
   localparam int ADDR_WIDTH = $clog2(CELL_COUNT);
   localparam int CELL_WIDTH = 16;
   localparam int COL_WIDTH  = 7;
   localparam int ROW_WIDTH  = 5;

   localparam logic [7:0] NEWLINE_CODE = 8'd10;
   localparam logic [7:0] SPACE_CODE   = 8'd32;
   localparam logic [7:0] RESET_COLOR  = 8'd9;

   typedef enum logic [1:0] {
      CMD_WRITE_CHAR,
      CMD_CLEAR,
      CMD_READ_CELL,
      CMD_PLACE
   } command_type;

   typedef enum logic [1:0] {
      CUR_HOLD,
      CUR_NEWLINE,
      CUR_ADVANCE
   } cursor_op_type;

   typedef enum logic [2:0] {
      MEM_NONE,
      MEM_READ_REQ,
      MEM_PLACE_REQ,
      MEM_CHAR,
      MEM_COPY,
      MEM_FILL
   } mem_op_type;

   typedef struct packed {
      logic          req_load;
      logic          cnt_clear;
      logic          cnt_inc;
      logic          fill_reset;
      logic          out_load;
      cursor_op_type cursor_op;
      mem_op_type    mem_op;
   } ctrl_type;

   typedef struct packed {
      logic wrap_pending;
      logic at_bottom;
      logic is_newline;
      logic copy_done;
      logic fill_done;
      logic out_free;
   } status_type;

endpackage

/* rtl/ttw_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ttw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/ttw_datapath.sv */
// Datapath of the text terminal writer: cursor, text color, walk counter,
// screen store and result register. Depends on ttw_pkg and ttw_ram.
module ttw_datapath
   import ttw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] req_tdata,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   input  ctrl_type    ctrl,
   output status_type  status
);

   logic [7:0]            char_code;
   logic [7:0]            cell_color;
   logic [COL_WIDTH-1:0]  column;
   logic [ROW_WIDTH-1:0]  row;
   logic                  in_range;
   logic [ADDR_WIDTH-1:0] req_addr;
   logic [ADDR_WIDTH-1:0] cursor_addr;

   logic [7:0]            text_color_ff;
   logic [COL_WIDTH-1:0]  col_ff, col_in;
   logic [ROW_WIDTH-1:0]  line_ff, line_in;
   logic [ADDR_WIDTH-1:0] cnt_ff, cnt_in;
   logic [7:0]            ch_ff, ch_in;
   logic                  read_hit_ff, read_hit_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CELL_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic [COL_WIDTH-1:0]  rsp_col_ff;
   logic [ROW_WIDTH-1:0]  rsp_row_ff;

   logic                  wr_en;
   logic [ADDR_WIDTH-1:0] wr_addr;
   logic [CELL_WIDTH-1:0] wr_data;
   logic                  rd_en;
   logic [ADDR_WIDTH-1:0] rd_addr;
   logic [CELL_WIDTH-1:0] rd_data;
   logic [7:0]            fill_color;

   assign char_code  = req_tdata[7:0];
   assign cell_color = req_tdata[15:8];
   assign column     = req_tdata[22:16];
   assign row        = req_tdata[27:23];
   assign in_range   = (column < COL_WIDTH'(COLUMNS)) && (row < ROW_WIDTH'(ROWS));
   assign req_addr   = ADDR_WIDTH'(row) * ADDR_WIDTH'(COLUMNS) + ADDR_WIDTH'(column);
   assign cursor_addr = ADDR_WIDTH'(line_ff) * ADDR_WIDTH'(COLUMNS) + ADDR_WIDTH'(col_ff);
   assign fill_color = ctrl.fill_reset ? RESET_COLOR : text_color_ff;

   always_comb begin
      col_in  = col_ff;
      line_in = line_ff;
      unique case (ctrl.cursor_op)
         CUR_NEWLINE: begin
            col_in = '0;
            if (line_ff != ROW_WIDTH'(ROWS - 1)) begin
               line_in = line_ff + ROW_WIDTH'(1);
            end
         end
         CUR_ADVANCE: begin
            col_in = col_ff + COL_WIDTH'(1);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (ctrl.cnt_clear || ctrl.req_load) begin
         cnt_in = '0;
      end else if (ctrl.cnt_inc) begin
         cnt_in = cnt_ff + ADDR_WIDTH'(1);
      end
      ch_in       = ctrl.req_load ? char_code : ch_ff;
      read_hit_in = ctrl.req_load ? ((ctrl.mem_op == MEM_READ_REQ) && in_range)
                                  : read_hit_ff;
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cnt_ff;
      wr_data = {fill_color, SPACE_CODE};
      rd_en   = 1'b0;
      rd_addr = req_addr;
      unique case (ctrl.mem_op)
         MEM_READ_REQ: begin
            rd_en = in_range;
         end
         MEM_PLACE_REQ: begin
            wr_en   = in_range;
            wr_addr = req_addr;
            wr_data = {cell_color, char_code};
         end
         MEM_CHAR: begin
            wr_en   = 1'b1;
            wr_addr = cursor_addr;
            wr_data = {text_color_ff, ch_ff};
         end
         MEM_COPY: begin
            rd_en   = (cnt_ff != ADDR_WIDTH'(COPY_COUNT));
            rd_addr = cnt_ff + ADDR_WIDTH'(COLUMNS);
            wr_en   = (cnt_ff != '0);
            wr_addr = cnt_ff - ADDR_WIDTH'(1);
            wr_data = rd_data;
         end
         MEM_FILL: begin
            wr_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   ttw_ram #(
      .WIDTH(CELL_WIDTH),
      .DEPTH(CELL_COUNT)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      rsp_value_in = read_hit_ff ? rd_data : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff <= RESET_COLOR;
         col_ff        <= '0;
         line_ff       <= ROW_WIDTH'(ROWS - 1);
         cnt_ff        <= '0;
         read_hit_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            text_color_ff <= csr_wr_data;
         end
         col_ff       <= col_in;
         line_ff      <= line_in;
         cnt_ff       <= cnt_in;
         read_hit_ff  <= read_hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff <= ch_in;
      if (ctrl.out_load) begin
         rsp_value_ff <= rsp_value_in;
         rsp_col_ff   <= col_in;
         rsp_row_ff   <= line_in;
      end
   end

   assign status.wrap_pending = (col_ff >= COL_WIDTH'(COLUMNS));
   assign status.at_bottom    = (line_ff == ROW_WIDTH'(ROWS - 1));
   assign status.is_newline   = (ch_ff == NEWLINE_CODE);
   assign status.copy_done    = (cnt_ff == ADDR_WIDTH'(COPY_COUNT));
   assign status.fill_done    = (cnt_ff == ADDR_WIDTH'(CELL_COUNT - 1));
   assign status.out_free     = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_row_ff, rsp_col_ff, rsp_value_ff};

endmodule

/* rtl/ttw_controller.sv */
// Sequencing state machine of the text terminal writer: request decode,
// scroll copy, screen fill and result hand-off. Depends on ttw_pkg.
module ttw_controller
   import ttw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [1:0] req_tuser,
   input  status_type status,
   output ctrl_type   ctrl
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHAR,
      S_COPY,
      S_FILL,
      S_FINISH
   } state_type;

   state_type   state_ff, state_in;
   state_type   ret_ff, ret_in;
   logic        fill_reset_ff, fill_reset_in;
   logic        accept;
   command_type command;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign command    = command_type'(req_tuser);

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      fill_reset_in = fill_reset_ff;
      ctrl          = '{req_load: 1'b0, cnt_clear: 1'b0, cnt_inc: 1'b0,
                        fill_reset: fill_reset_ff, out_load: 1'b0,
                        cursor_op: CUR_HOLD, mem_op: MEM_NONE};
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ctrl.req_load = 1'b1;
               unique case (command)
                  CMD_WRITE_CHAR: begin
                     state_in = S_CHAR;
                     if (status.wrap_pending) begin
                        ctrl.cursor_op = CUR_NEWLINE;
                        if (status.at_bottom) begin
                           state_in = S_COPY;
                           ret_in   = S_CHAR;
                        end
                     end
                  end
                  CMD_CLEAR: begin
                     state_in = S_FILL;
                     ret_in   = S_FINISH;
                  end
                  CMD_READ_CELL: begin
                     ctrl.mem_op = MEM_READ_REQ;
                     state_in    = S_FINISH;
                  end
                  CMD_PLACE: begin
                     ctrl.mem_op = MEM_PLACE_REQ;
                     state_in    = S_FINISH;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_CHAR: begin
            if (status.is_newline && status.at_bottom) begin
               ctrl.cursor_op = CUR_NEWLINE;
               ctrl.cnt_clear = 1'b1;
               state_in       = S_COPY;
               ret_in         = S_FINISH;
            end else if (status.out_free) begin
               if (status.is_newline) begin
                  ctrl.cursor_op = CUR_NEWLINE;
               end else begin
                  ctrl.mem_op    = MEM_CHAR;
                  ctrl.cursor_op = CUR_ADVANCE;
               end
               ctrl.out_load = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_COPY: begin
            ctrl.mem_op = MEM_COPY;
            if (status.copy_done) begin
               state_in = S_FILL;
            end else begin
               ctrl.cnt_inc = 1'b1;
            end
         end
         S_FILL: begin
            ctrl.mem_op  = MEM_FILL;
            ctrl.cnt_inc = 1'b1;
            if (status.fill_done) begin
               fill_reset_in = 1'b0;
               state_in      = ret_ff;
            end
         end
         S_FINISH: begin
            if (status.out_free) begin
               ctrl.out_load = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_FILL;
         ret_ff        <= S_IDLE;
         fill_reset_ff <= 1'b1;
      end else begin
         state_ff      <= state_in;
         ret_ff        <= ret_in;
         fill_reset_ff <= fill_reset_in;
      end
   end

endmodule

/* rtl/text_terminal_writer_top.sv */
// Top level of the text terminal writer: joins the controller and the datapath.
// Depends on ttw_pkg, ttw_controller and ttw_datapath.
//
// An 80x25 text screen of 16-bit cells (color in the high byte, character in
// the low byte) held in one single-port-read, single-port-write RAM. After
// reset the block sweeps the RAM one cell per cycle to fill it with spaces in
// color 9 before the first request is taken; color register writes are taken
// at any time. A request is taken only while the block is idle, and every
// request returns exactly one result, which waits in an output register so
// the next request can be taken meanwhile. A clear fills the whole RAM. A new
// line on the bottom row scrolls by copying 1920 cells through the RAM read
// port and then filling the last row; a character that both wraps and is a
// newline on the bottom row scrolls twice.
module text_terminal_writer_top
   import ttw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // Fields from bit 0: char_code[7:0], cell_color[15:8], column[22:16],
   // row[27:23], zero fill[31:28].
   input  logic [31:0] req_tdata,
   // Fields from bit 0: command[1:0].
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Fields from bit 0: cell_value[15:0], cursor_column[22:16],
   // cursor_row[27:23], zero fill[31:28].
   output logic [31:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   ctrl_type   ctrl;
   status_type status;

   ttw_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser (req_tuser),
      .status    (status),
      .ctrl      (ctrl)
   );

   ttw_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .ctrl       (ctrl),
      .status     (status)
   );

endmodule

/* verif/ttw_screen_checker.sv */
`timescale 1ns / 1ps
// Checker for the text terminal writer: watches the request, result and color
// register channels, keeps a shadow screen and cursor, and compares results.
// Depends on ttw_pkg.
module ttw_screen_checker
   import ttw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   output int          errors,
   output int          pending
);

   typedef struct {
      logic [15:0] cell_val;
      logic [6:0]  col_after;
      logic [4:0]  row_after;
   } term_reply;

   logic [15:0] shadow_screen [CELL_COUNT];
   logic [6:0]  cursor_x;
   logic [4:0]  cursor_y;
   logic [7:0]  text_color;
   term_reply   terminal_replies [$];

   initial begin
      errors = 0;
      pending = 0;
   end

   task automatic report_mismatch(input string field_name, input int want, input int got);
      if (errors < 40) begin
         $display("[%0t ns] %s: expected 0x%0h, got 0x%0h", $time, field_name, want, got);
      end
      errors++;
   endtask

   function automatic void scroll_shadow();
      int i;
      for (i = 0; i < COPY_COUNT; i++) begin
         shadow_screen[i] = shadow_screen[i + COLUMNS];
      end
      for (i = COPY_COUNT; i < CELL_COUNT; i++) begin
         shadow_screen[i] = {text_color, SPACE_CODE};
      end
   endfunction

   function automatic void start_line();
      cursor_x = '0;
      if (cursor_y == ROWS - 1) begin
         scroll_shadow();
      end else begin
         cursor_y = cursor_y + 1'b1;
      end
   endfunction

   function automatic term_reply run_terminal_op(input command_type op, input logic [7:0] ch,
                                                 input logic [7:0] color, input logic [6:0] col,
                                                 input logic [4:0] row);
      term_reply r;
      logic      on_screen;
      int        i;
      on_screen = (col < COLUMNS) && (row < ROWS);
      r.cell_val = '0;
      case (op)
         CMD_WRITE_CHAR: begin
            if (cursor_x >= COLUMNS) begin
               start_line();
            end
            if (ch == NEWLINE_CODE) begin
               start_line();
            end else begin
               shadow_screen[cursor_y * COLUMNS + cursor_x] = {text_color, ch};
               cursor_x = cursor_x + 1'b1;
            end
         end
         CMD_CLEAR: begin
            for (i = 0; i < CELL_COUNT; i++) begin
               shadow_screen[i] = {text_color, SPACE_CODE};
            end
         end
         CMD_READ_CELL: begin
            if (on_screen) begin
               r.cell_val = shadow_screen[row * COLUMNS + col];
            end
         end
         default: begin
            if (on_screen) begin
               shadow_screen[row * COLUMNS + col] = {color, ch};
            end
         end
      endcase
      r.col_after = cursor_x;
      r.row_after = cursor_y;
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      term_reply got;
      term_reply want;
      int        i;
      if (reset) begin
         for (i = 0; i < CELL_COUNT; i++) begin
            shadow_screen[i] = {RESET_COLOR, SPACE_CODE};
         end
         cursor_x = '0;
         cursor_y = ROW_WIDTH'(ROWS - 1);
         text_color = RESET_COLOR;
         terminal_replies.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.cell_val = rsp_tdata[15:0];
            got.col_after = rsp_tdata[22:16];
            got.row_after = rsp_tdata[27:23];
            if (terminal_replies.size() == 0) begin
               report_mismatch("result with no request waiting", 0, int'(rsp_tdata));
            end else begin
               want = terminal_replies.pop_front();
               if (got.cell_val !== want.cell_val) begin
                  report_mismatch("cell_value", int'(want.cell_val), int'(got.cell_val));
               end
               if (got.col_after !== want.col_after) begin
                  report_mismatch("cursor_column", int'(want.col_after),
                                  int'(got.col_after));
               end
               if (got.row_after !== want.row_after) begin
                  report_mismatch("cursor_row", int'(want.row_after), int'(got.row_after));
               end
            end
         end
         if (csr_wr_en) begin
            text_color = csr_wr_data;
         end
         if (req_tvalid && req_tready) begin
            terminal_replies.push_back(run_terminal_op(command_type'(req_tuser), req_tdata[7:0],
                                                       req_tdata[15:8], req_tdata[22:16],
                                                       req_tdata[27:23]));
         end
      end
      pending = terminal_replies.size();
   end

endmodule

/* verif/text_terminal_writer_top_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the text terminal writer: drives requests, results
// backpressure and color writes, and gives the verdict.
// Depends on ttw_pkg, text_terminal_writer_top and ttw_screen_checker.
module text_terminal_writer_top_tb;
   import ttw_pkg::*;

   localparam int STALL_LIMIT = 25000;
   localparam int PHASE_ITEMS = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // Fields from bit 0: char_code, cell_color, column, row, zero fill.
   logic [31:0] req_tdata = '0;
   // Fields from bit 0: command.
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // Fields from bit 0: cell_value, cursor_column, cursor_row, zero fill.
   logic [31:0] rsp_tdata;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = '0;

   int errors;
   int pending;
   int quiet_cycles = 0;
   bit idle_on = 1'b1;
   bit hold_sink = 1'b0;
   int n_sent = 0;
   int n_writes = 0;
   int n_newlines = 0;
   int n_clears = 0;
   int n_reads = 0;
   int n_places = 0;
   int n_colors = 0;

   text_terminal_writer_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   ttw_screen_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .errors      (errors),
      .pending     (pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timed out after %0d cycles without a handshake.", quiet_cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin : result_sink
      int gap;
      forever begin
         if (hold_sink) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_sink = 1'b0;
         end
         gap = idle_on ? $urandom_range(0, 4) : 0;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   task automatic send_req(input command_type op, input logic [7:0] ch, input logic [7:0] color,
                           input logic [6:0] col, input logic [4:0] row);
      int gap;
      gap = idle_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {4'b0000, row, col, color, ch};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      n_sent++;
      case (op)
         CMD_WRITE_CHAR: begin
            n_writes++;
            if (ch == NEWLINE_CODE) n_newlines++;
         end
         CMD_CLEAR: n_clears++;
         CMD_READ_CELL: n_reads++;
         default: n_places++;
      endcase
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0 || !req_tready);
      @(posedge clock);
   endtask

   task automatic set_color(input logic [7:0] value);
      settle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      n_colors++;
   endtask

   initial begin : stimulus
      int          phase;
      int          phase_start;
      int          pick;
      int          n;
      int          k;
      logic [7:0]  ch;
      logic [6:0]  col;
      logic [4:0]  row;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_req(CMD_READ_CELL, 8'h00, 8'h00, 7'd0, 5'd0);
      send_req(CMD_READ_CELL, 8'h00, 8'h00, 7'd79, 5'd24);
      send_req(CMD_READ_CELL, 8'h00, 8'h00, 7'd80, 5'd0);
      send_req(CMD_READ_CELL, 8'hFF, 8'hFF, 7'd127, 5'd31);
      send_req(CMD_READ_CELL, 8'h00, 8'h00, 7'd0, 5'd25);
      send_req(CMD_PLACE, 8'h00, 8'h00, 7'd0, 5'd0);
      send_req(CMD_PLACE, 8'hFF, 8'hFF, 7'd79, 5'd24);
      send_req(CMD_PLACE, 8'h55, 8'hAA, 7'd80, 5'd24);
      send_req(CMD_PLACE, 8'hAA, 8'h55, 7'd0, 5'd25);
      send_req(CMD_PLACE, 8'hFF, 8'hFF, 7'd127, 5'd31);
      send_req(CMD_READ_CELL, 8'h00, 8'h00, 7'd0, 5'd0);
      send_req(CMD_READ_CELL, 8'h00, 8'h00, 7'd79, 5'd24);
      send_req(CMD_READ_CELL, 8'h00, 8'h00, 7'd79, 5'd0);
      send_req(CMD_WRITE_CHAR, 8'h00, 8'h00, 7'd0, 5'd0);
      send_req(CMD_WRITE_CHAR, 8'hFF, 8'hFF, 7'd127, 5'd31);
      send_req(CMD_WRITE_CHAR, 8'h41, 8'h00, 7'd0, 5'd0);
      send_req(CMD_WRITE_CHAR, NEWLINE_CODE, 8'h00, 7'd0, 5'd0);
      send_req(CMD_READ_CELL, 8'h00, 8'h00, 7'd0, 5'd23);
      send_req(CMD_READ_CELL, 8'h00, 8'h00, 7'd79, 5'd23);
      send_req(CMD_READ_CELL, 8'h00, 8'h00, 7'd0, 5'd24);
      send_req(CMD_CLEAR, 8'h00, 8'h00, 7'd0, 5'd0);
      send_req(CMD_READ_CELL, 8'h00, 8'h00, 7'd79, 5'd24);
      send_req(CMD_READ_CELL, 8'h00, 8'h00, 7'd40, 5'd12);
      send_req(CMD_PLACE, NEWLINE_CODE, 8'h0F, 7'd5, 5'd5);
      send_req(CMD_READ_CELL, 8'h00, 8'h00, 7'd5, 5'd5);

      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0: set_color(8'h00);
            1: set_color(8'hFF);
            4: set_color(RESET_COLOR);
            default: set_color(8'($urandom_range(0, 255)));
         endcase
         idle_on = (phase != 2);
         if (phase == 1) hold_sink = 1'b1;
         phase_start = n_sent;
         while (n_sent - phase_start < PHASE_ITEMS) begin
            if (phase == 3 && n_sent - phase_start >= PHASE_ITEMS / 2 &&
                n_sent - phase_start < PHASE_ITEMS / 2 + 4) begin
               settle();
            end
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
               k = $urandom_range(0, 99);
               if (k < 60) n = $urandom_range(0, 20);
               else if (k < 80) n = COLUMNS;
               else n = $urandom_range(COLUMNS - 10, COLUMNS + 10);
               repeat (n) begin
                  do ch = 8'($urandom_range(0, 255)); while (ch == NEWLINE_CODE);
                  send_req(CMD_WRITE_CHAR, ch, 8'($urandom_range(0, 255)),
                           7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)));
               end
               if ($urandom_range(0, 99) < 85) begin
                  send_req(CMD_WRITE_CHAR, NEWLINE_CODE, 8'($urandom_range(0, 255)),
                           7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)));
               end
            end else if (pick < 75) begin
               repeat ($urandom_range(1, 5)) begin
                  if ($urandom_range(0, 9) == 0) begin
                     col = 7'($urandom_range(0, 127));
                     row = 5'($urandom_range(0, 31));
                  end else begin
                     col = 7'($urandom_range(0, COLUMNS - 1));
                     row = 5'($urandom_range(ROWS - 5, ROWS - 1));
                  end
                  send_req(CMD_READ_CELL, 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), col, row);
               end
            end else if (pick < 90) begin
               repeat ($urandom_range(1, 3)) begin
                  if ($urandom_range(0, 9) == 0) begin
                     col = 7'($urandom_range(0, 127));
                     row = 5'($urandom_range(0, 31));
                  end else begin
                     col = 7'($urandom_range(0, COLUMNS - 1));
                     row = 5'($urandom_range(0, ROWS - 1));
                  end
                  send_req(CMD_PLACE, 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), col, row);
               end
            end else if (pick < 94) begin
               send_req(CMD_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)));
            end else begin
               send_req(command_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                        5'($urandom_range(0, 31)));
            end
         end
      end

      settle();
      repeat (16) @(posedge clock);
      $display("Covered %0d requests: %0d character writes with %0d newlines, %0d clears,",
               n_sent, n_writes, n_newlines, n_clears);
      $display("%0d reads and %0d placements, over %0d text colors with stalls on both sides.",
               n_reads, n_places, n_colors);
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/ttw_pkg.sv
rtl/ttw_ram.sv
rtl/ttw_datapath.sv
rtl/ttw_controller.sv
rtl/text_terminal_writer_top.sv
verif/ttw_screen_checker.sv
verif/text_terminal_writer_top_tb.sv
